[sv/inplace_heap_sorter_assert.svh]
// Assertion macros for the heap sorter.
`ifndef INPLACE_HEAP_SORTER_ASSERT_SVH
`define INPLACE_HEAP_SORTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IHS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IHS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define IHS_ASSERT(lbl, clk, rst_n, prop, msg)
`define IHS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

[sv/ihs_pkg.sv]
// Shared constants, types and controller commands for the heap sorter.
package ihs_pkg;

  localparam int DEPTH = 64;
  localparam int WIDTH = 32;
  localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW    = AW + 1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PREP,
    ST_SIFT_RD,
    ST_SIFT_HOLD,
    ST_SIFT_CMP,
    ST_SIFT_PUT,
    ST_EXT_RD,
    ST_EXT_SWAP,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } ihs_state_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_HELD,
    WR_CHILD,
    WR_SWAP
  } ihs_wr_sel_t;

  typedef enum logic [2:0] {
    ADDR_IDX,
    ADDR_KIDS_POS,
    ADDR_KIDS_CHILD,
    ADDR_EXT,
    ADDR_ROOT_KIDS
  } ihs_addr_sel_t;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_IDX,
    POS_CHILD,
    POS_ZERO
  } ihs_pos_op_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_START,
    IDX_DEC,
    IDX_LAST,
    IDX_ZERO,
    IDX_INC
  } ihs_idx_op_t;

  typedef enum logic [1:0] {
    HELD_HOLD,
    HELD_RDA,
    HELD_RDB
  } ihs_held_op_t;

  typedef enum logic [1:0] {
    SIZE_HOLD,
    SIZE_COUNT,
    SIZE_IDX
  } ihs_size_op_t;

  typedef struct packed {
    logic          in_ready;
    ihs_wr_sel_t   wr_sel;
    ihs_addr_sel_t addr_sel;
    ihs_pos_op_t   pos_op;
    ihs_idx_op_t   idx_op;
    ihs_held_op_t  held_op;
    ihs_size_op_t  size_op;
    logic          out_ld;
    logic          clear;
  } ihs_cmd_t;

  typedef struct packed {
    logic kid_has;
    logic stop;
    logic child_has_kids;
    logic idx_zero;
    logic idx_one;
    logic emit_last;
    logic n_lt2;
    logic out_fire;
  } ihs_stat_t;

endpackage

[sv/ihs_if.sv]
// Input and result channel interfaces of the heap sorter.
interface ihs_in_if import ihs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] value;
  logic                    last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface ihs_out_if import ihs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] sorted_value;
  logic                    final_res;
  logic                    overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input final_res, input overflow,
                output ready);
endinterface

[sv/inplace_heap_sorter.sv]
// Heap sorter top level: channel hookup of controller and datapath, and assertions.
//
//   channel  direction  payload                              transaction when
//   in_if    sink       value, last                          valid && ready
//   out_if   source     sorted_value, final_res, overflow    valid && ready
//
// Loading accepts one element per cycle; ready is high only while loading.
// Sorting runs n/2 (rounded down) build sifts, then n - 1 extraction sifts (one store write a cycle).
// Each result goes through a store read, an output register load and a handshake.
// Reset clears the element count, the drop flag and the result valid; no store clear.
// A stalled result holds in the output register; no input is taken until the
// final result of the set is accepted.
`include "inplace_heap_sorter_assert.svh"

module inplace_heap_sorter import ihs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ihs_in_if.sink    in_if,
  ihs_out_if.source out_if
);

  ihs_cmd_t  cmd;
  ihs_stat_t stat;
  logic      in_fire;
  logic      last_fire;
  logic      final_fire;

  assign in_if.ready = cmd.in_ready;
  assign in_fire     = in_if.valid && cmd.in_ready;
  assign last_fire   = in_fire && in_if.last;
  assign final_fire  = out_if.valid && out_if.ready && out_if.final_res;

  ihs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_last (in_if.last),
    .stat    (stat),
    .cmd     (cmd)
  );

  ihs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_fire   (in_fire),
    .in_value  (in_if.value),
    .out_ready (out_if.ready),
    .stat      (stat),
    .out_valid (out_if.valid),
    .out_value (out_if.sorted_value),
    .out_final (out_if.final_res),
    .out_ovf   (out_if.overflow)
  );

  `IHS_ASSERT(a_no_result_while_loading, clk, rst_n, in_if.ready |-> !out_if.valid, "out valid")
  `IHS_ASSERT_NEXT(a_ready_after_final, clk, rst_n, final_fire, in_if.ready, "not ready")
  `IHS_ASSERT_NEXT(a_busy_after_last, clk, rst_n, last_fire, !in_if.ready, "taken after last")

endmodule

[sv/ihs_datapath.sv]
// Heap sorter datapath: element store, sift registers, child compare and result register.
module ihs_datapath import ihs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ihs_cmd_t                cmd,
  input  logic                    in_fire,
  input  logic signed [WIDTH-1:0] in_value,
  input  logic                    out_ready,
  output ihs_stat_t               stat,
  output logic                    out_valid,
  output logic signed [WIDTH-1:0] out_value,
  output logic                    out_final,
  output logic                    out_ovf
);

  logic signed [WIDTH-1:0] mem [DEPTH];
  logic signed [WIDTH-1:0] rda_r;
  logic signed [WIDTH-1:0] rdb_r;

  logic [CW-1:0]           count_r;
  logic                    drop_r;
  logic [CW-1:0]           size_r;
  logic [AW-1:0]           idx_r;
  logic [AW-1:0]           pos_r;
  logic signed [WIDTH-1:0] held_r;

  logic                    out_valid_r;
  logic signed [WIDTH-1:0] out_value_r;
  logic                    out_final_r;
  logic                    out_ovf_r;

  logic [CW:0]             size_x;
  logic [CW:0]             lkid;
  logic [CW:0]             rkid;
  logic [CW:0]             gkid;
  logic [CW:0]             gkid_rgt;
  logic                    right_ok;
  logic                    pick_right;
  logic [CW:0]             child_idx;
  logic signed [WIDTH-1:0] child_val;
  logic                    full;

  logic [AW-1:0]           rd_a;
  logic [AW-1:0]           rd_b;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [WIDTH-1:0] wr_data;

  assign full       = (count_r == CW'(DEPTH));
  assign size_x     = {1'b0, size_r};
  assign lkid       = {1'b0, pos_r, 1'b1};
  assign rkid       = lkid + (CW+1)'(1);
  assign right_ok   = (rkid < size_x);
  assign pick_right = right_ok && (rdb_r > rda_r);
  assign child_idx  = pick_right ? rkid : lkid;
  assign child_val  = pick_right ? rdb_r : rda_r;
  assign gkid       = {1'b0, child_idx[AW-1:0], 1'b1};
  assign gkid_rgt   = gkid + (CW+1)'(1);

  always_comb begin
    stat.kid_has        = (lkid < size_x);
    stat.stop           = (held_r >= child_val);
    stat.child_has_kids = (gkid < size_x);
    stat.idx_zero       = (idx_r == '0);
    stat.idx_one        = (idx_r == AW'(1));
    stat.emit_last      = ({1'b0, idx_r} == (count_r - CW'(1)));
    stat.n_lt2          = (count_r < CW'(2));
    stat.out_fire       = out_valid_r && out_ready;
  end

  always_comb begin
    case (cmd.addr_sel)
      ADDR_IDX: begin
        rd_a = idx_r;
        rd_b = idx_r;
      end
      ADDR_KIDS_POS: begin
        rd_a = lkid[AW-1:0];
        rd_b = rkid[AW-1:0];
      end
      ADDR_KIDS_CHILD: begin
        rd_a = gkid[AW-1:0];
        rd_b = gkid_rgt[AW-1:0];
      end
      ADDR_EXT: begin
        rd_a = '0;
        rd_b = idx_r;
      end
      ADDR_ROOT_KIDS: begin
        rd_a = AW'(1);
        rd_b = AW'(2);
      end
      default: begin
        rd_a = idx_r;
        rd_b = idx_r;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = held_r;
    if (in_fire && !full) begin
      wr_en   = 1'b1;
      wr_addr = count_r[AW-1:0];
      wr_data = in_value;
    end else begin
      case (cmd.wr_sel)
        WR_HELD: begin
          wr_en   = 1'b1;
          wr_addr = pos_r;
          wr_data = held_r;
        end
        WR_CHILD: begin
          wr_en   = 1'b1;
          wr_addr = pos_r;
          wr_data = child_val;
        end
        WR_SWAP: begin
          wr_en   = 1'b1;
          wr_addr = idx_r;
          wr_data = rda_r;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rda_r <= mem[rd_a];
    rdb_r <= mem[rd_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
        drop_r  <= 1'b0;
      end else if (in_fire) begin
        if (full) begin
          drop_r <= 1'b1;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (stat.out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.size_op)
      SIZE_COUNT: size_r <= count_r;
      SIZE_IDX:   size_r <= {1'b0, idx_r};
      default:    size_r <= size_r;
    endcase
    case (cmd.idx_op)
      IDX_START: idx_r <= stat.n_lt2 ? '0 : AW'((count_r - CW'(2)) >> 1);
      IDX_DEC:   idx_r <= idx_r - AW'(1);
      IDX_LAST:  idx_r <= AW'(count_r - CW'(1));
      IDX_ZERO:  idx_r <= '0;
      IDX_INC:   idx_r <= idx_r + AW'(1);
      default:   idx_r <= idx_r;
    endcase
    case (cmd.pos_op)
      POS_IDX:   pos_r <= idx_r;
      POS_CHILD: pos_r <= child_idx[AW-1:0];
      POS_ZERO:  pos_r <= '0;
      default:   pos_r <= pos_r;
    endcase
    case (cmd.held_op)
      HELD_RDA: held_r <= rda_r;
      HELD_RDB: held_r <= rdb_r;
      default:  held_r <= held_r;
    endcase
    if (cmd.out_ld) begin
      out_value_r <= rda_r;
      out_final_r <= stat.emit_last;
      out_ovf_r   <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_final = out_final_r;
  assign out_ovf   = out_ovf_r;

endmodule

[sv/ihs_ctrl.sv]
// Heap sorter controller: load, heap build, extraction and emit sequencing.
module ihs_ctrl import ihs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      in_last,
  input  ihs_stat_t stat,
  output ihs_cmd_t  cmd
);

  ihs_state_t state_r;
  ihs_state_t state_nxt;
  logic       build_r;
  logic       build_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      build_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      build_r <= build_nxt;
    end
  end

  always_comb begin
    logic sift_done;
    sift_done    = 1'b0;
    state_nxt    = state_r;
    build_nxt    = build_r;
    cmd.in_ready = 1'b0;
    cmd.wr_sel   = WR_NONE;
    cmd.addr_sel = ADDR_IDX;
    cmd.pos_op   = POS_HOLD;
    cmd.idx_op   = IDX_HOLD;
    cmd.held_op  = HELD_HOLD;
    cmd.size_op  = SIZE_HOLD;
    cmd.out_ld   = 1'b0;
    cmd.clear    = 1'b0;

    case (state_r)
      ST_LOAD: begin
        cmd.in_ready = 1'b1;
        if (in_fire && in_last) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.size_op = SIZE_COUNT;
        cmd.idx_op  = IDX_START;
        if (stat.n_lt2) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          build_nxt = 1'b1;
          state_nxt = ST_SIFT_RD;
        end
      end
      ST_SIFT_RD: begin
        cmd.addr_sel = ADDR_IDX;
        cmd.pos_op   = POS_IDX;
        state_nxt    = ST_SIFT_HOLD;
      end
      ST_SIFT_HOLD: begin
        cmd.held_op = HELD_RDA;
        if (stat.kid_has) begin
          cmd.addr_sel = ADDR_KIDS_POS;
          state_nxt    = ST_SIFT_CMP;
        end else begin
          sift_done = 1'b1;
        end
      end
      ST_SIFT_CMP: begin
        if (stat.stop) begin
          cmd.wr_sel = WR_HELD;
          sift_done  = 1'b1;
        end else begin
          cmd.wr_sel = WR_CHILD;
          cmd.pos_op = POS_CHILD;
          if (stat.child_has_kids) begin
            cmd.addr_sel = ADDR_KIDS_CHILD;
          end else begin
            state_nxt = ST_SIFT_PUT;
          end
        end
      end
      ST_SIFT_PUT: begin
        cmd.wr_sel = WR_HELD;
        sift_done  = 1'b1;
      end
      ST_EXT_RD: begin
        cmd.addr_sel = ADDR_EXT;
        state_nxt    = ST_EXT_SWAP;
      end
      ST_EXT_SWAP: begin
        cmd.wr_sel  = WR_SWAP;
        cmd.held_op = HELD_RDB;
        cmd.pos_op  = POS_ZERO;
        cmd.size_op = SIZE_IDX;
        if (stat.idx_one) begin
          state_nxt = ST_SIFT_PUT;
        end else begin
          cmd.addr_sel = ADDR_ROOT_KIDS;
          state_nxt    = ST_SIFT_CMP;
        end
      end
      ST_EMIT_RD: begin
        cmd.addr_sel = ADDR_IDX;
        state_nxt    = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd.out_ld = 1'b1;
        state_nxt  = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (stat.out_fire) begin
          if (stat.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_LOAD;
          end else begin
            cmd.idx_op = IDX_INC;
            state_nxt  = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        build_nxt = 1'b0;
      end
    endcase

    if (sift_done) begin
      if (build_r) begin
        if (stat.idx_zero) begin
          build_nxt  = 1'b0;
          cmd.idx_op = IDX_LAST;
          state_nxt  = ST_EXT_RD;
        end else begin
          cmd.idx_op = IDX_DEC;
          state_nxt  = ST_SIFT_RD;
        end
      end else begin
        if (stat.idx_one) begin
          cmd.idx_op = IDX_ZERO;
          state_nxt  = ST_EMIT_RD;
        end else begin
          cmd.idx_op = IDX_DEC;
          state_nxt  = ST_EXT_RD;
        end
      end
    end
  end

endmodule
